@@ hdl/ptg_pkg.sv @@
// ----------------------------------------------------------------------------
// Partition tuple generator package
// Shared constants, register indexes, the permutation state record and the
// position helpers used by the swap walk.
// ----------------------------------------------------------------------------
package ptg_pkg;

    localparam int FIELD_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PARTS_W    = 2;
    localparam int PEND_W     = 3;
    localparam int POS_W      = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERMUTE = 2'd2;

    // Part count codes.
    localparam logic [PARTS_W-1:0] PARTS_TWO   = 2'd2;
    localparam logic [PARTS_W-1:0] PARTS_THREE = 2'd3;

    // Number of reorderings still to walk after a base tuple.
    localparam logic [PEND_W-1:0] PERM_NONE         = 3'd0;
    localparam logic [PEND_W-1:0] PERM_SINGLE       = 3'd1;
    localparam logic [PEND_W-1:0] PERM_ONE_PAIR     = 3'd2;
    localparam logic [PEND_W-1:0] PERM_ALL_DISTINCT = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0]  swap_pos;
        logic [PEND_W-1:0] pending;
    } perm_t;

    // Reduce a stored position modulo the live part count.
    function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W-1:0] pos,
                                                 input logic three);
        logic [POS_W-1:0] r;
        if (three) begin
            r = (pos == 2'd3) ? 2'd0 : pos;
        end else begin
            r = {1'b0, pos[0]};
        end
        return r;
    endfunction

    // Cyclic successor of an already reduced position.
    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos,
                                                 input logic three);
        logic [POS_W-1:0] r;
        if (three) begin
            r = (pos == 2'd2) ? 2'd0 : pos + 2'd1;
        end else begin
            r = {1'b0, ~pos[0]};
        end
        return r;
    endfunction

endpackage

@@ hdl/partition_tuple_generator_core.sv @@
// ----------------------------------------------------------------------------
// Partition tuple generator core
// Enumerates the splits of a total into two or three positive parts, with
// optional walking of the distinct reorderings of each tuple.
// ----------------------------------------------------------------------------
// Usage: each request on the s_ channel carries s_restart. A restart reloads
// the counters from the configuration registers and returns an all-zero
// tuple with tuple_valid low; m_more_left says whether a tuple can follow.
// Any other request returns the next tuple, or zeros with both flags low
// once the sequence is exhausted. Exactly one result leaves on the m_
// channel per request, in order.
// Configuration (total, parts, permute_on) is written through the cfg_
// channel, which is always ready; it should only be written while no
// request is in flight.
// Timing: a request is captured in an input register and then evaluated
// by the step logic into the result register, which drives m_valid. One
// request per cycle is sustained while the receiver keeps m_ready high.
// When the receiver stalls, the result register holds and one further
// request may wait in the input register before s_ready drops. Synchronous
// reset returns the configuration to total 2, two parts, no reordering,
// and empties both registers.
// ----------------------------------------------------------------------------
module partition_tuple_generator_core #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ptg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptg_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_restart,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ptg_pkg::FIELD_W-1:0]      m_part_first,
    output logic [ptg_pkg::FIELD_W-1:0]      m_part_second,
    output logic [ptg_pkg::FIELD_W-1:0]      m_part_third,
    output logic                             m_tuple_valid,
    output logic                             m_more_left
);

    // Configuration registers.
    logic [VALUE_WIDTH-1:0]       total_reg;
    logic [ptg_pkg::PARTS_W-1:0]  parts_reg;
    logic                         permute_reg;

    // Generator state.
    logic [VALUE_WIDTH-1:0] lead_reg,   lead_next;
    logic [VALUE_WIDTH-1:0] middle_reg, middle_next;
    logic [VALUE_WIDTH-1:0] tail_reg,   tail_next;
    logic [VALUE_WIDTH-1:0] tuple_reg  [3];
    logic [VALUE_WIDTH-1:0] tuple_next [3];
    ptg_pkg::perm_t         perm_reg,   perm_next;

    // Input register and result register.
    logic                   in_valid_reg;
    logic                   restart_reg;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] first_reg, second_reg, third_reg;
    logic                   tvalid_reg;

    logic [VALUE_WIDTH-1:0] res_first, res_second, res_third;
    logic                   res_valid;
    logic                   more_now;
    logic                   three;
    logic                   fire;
    logic                   s_take;

    assign three = (parts_reg == ptg_pkg::PARTS_THREE);

    // The step fires when a request is waiting and the result slot is free
    // or is being emptied in this same cycle.
    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || fire;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    ptg_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .total       (total_reg),
        .three       (three),
        .permute_on  (permute_reg),
        .restart     (restart_reg),
        .lead        (lead_reg),
        .middle      (middle_reg),
        .tail        (tail_reg),
        .tuple_in    (tuple_reg),
        .perm_in     (perm_reg),
        .lead_next   (lead_next),
        .middle_next (middle_next),
        .tail_next   (tail_next),
        .tuple_next  (tuple_next),
        .perm_next   (perm_next),
        .res_first   (res_first),
        .res_second  (res_second),
        .res_third   (res_third),
        .res_valid   (res_valid),
        .more_now    (more_now)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= VALUE_WIDTH'(2);
            parts_reg     <= ptg_pkg::PARTS_TWO;
            permute_reg   <= 1'b0;
            lead_reg      <= VALUE_WIDTH'(1);
            middle_reg    <= VALUE_WIDTH'(1);
            tail_reg      <= '0;
            tuple_reg[0]  <= '0;
            tuple_reg[1]  <= '0;
            tuple_reg[2]  <= '0;
            perm_reg      <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    // Configuration data is 16 bits; it is sized to the value width.
                    ptg_pkg::REG_TOTAL:   total_reg   <= VALUE_WIDTH'(cfg_data);
                    ptg_pkg::REG_PARTS:   parts_reg   <= cfg_data[ptg_pkg::PARTS_W-1:0];
                    ptg_pkg::REG_PERMUTE: permute_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                out_valid_reg <= 1'b1;
                lead_reg      <= lead_next;
                middle_reg    <= middle_next;
                tail_reg      <= tail_next;
                tuple_reg     <= tuple_next;
                perm_reg      <= perm_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            restart_reg <= s_restart;
        end
        if (fire) begin
            first_reg  <= res_first;
            second_reg <= res_second;
            third_reg  <= res_third;
            tvalid_reg <= res_valid;
        end
    end

    // The result register always holds the newest evaluated request, so the
    // state registers describe the generator just after it; the more flag is
    // therefore read straight from them.
    assign m_valid       = out_valid_reg;
    assign m_part_first  = ptg_pkg::FIELD_W'(32'(first_reg));
    assign m_part_second = ptg_pkg::FIELD_W'(32'(second_reg));
    assign m_part_third  = ptg_pkg::FIELD_W'(32'(third_reg));
    assign m_tuple_valid = tvalid_reg;
    assign m_more_left   = more_now;

endmodule

@@ hdl/ptg_swap.sv @@
// ----------------------------------------------------------------------------
// Partition tuple generator: reordering step
// Finds the next cyclically adjacent pair of unequal values, at most three
// probes, and exchanges them.
// ----------------------------------------------------------------------------
module ptg_swap #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic [VALUE_WIDTH-1:0] tuple_in  [3],
    input  logic                   three,
    input  ptg_pkg::perm_t         perm_in,
    output logic [VALUE_WIDTH-1:0] tuple_out [3],
    output ptg_pkg::perm_t         perm_out
);

    logic [ptg_pkg::POS_W-1:0] p0, n0, n1, n2;
    logic [ptg_pkg::POS_W-1:0] sp, sn;
    logic                      found;

    always_comb begin
        p0 = ptg_pkg::wrap_pos(perm_in.swap_pos, three);
        n0 = ptg_pkg::next_pos(p0, three);
        n1 = ptg_pkg::next_pos(n0, three);
        n2 = ptg_pkg::next_pos(n1, three);
        found = 1'b1;
        if (tuple_in[p0] != tuple_in[n0]) begin
            sp = p0;
            sn = n0;
        end else if (tuple_in[n0] != tuple_in[n1]) begin
            sp = n0;
            sn = n1;
        end else if (tuple_in[n1] != tuple_in[n2]) begin
            sp = n1;
            sn = n2;
        end else begin
            // Every probed pair was equal: position still advances.
            found = 1'b0;
            sp = n1;
            sn = n2;
        end

        tuple_out = tuple_in;
        if (found) begin
            tuple_out[sp] = tuple_in[sn];
            tuple_out[sn] = tuple_in[sp];
        end
        perm_out.swap_pos = sn;
        perm_out.pending  = perm_in.pending - ptg_pkg::PERM_SINGLE;
    end

endmodule

@@ hdl/ptg_step.sv @@
// ----------------------------------------------------------------------------
// Partition tuple generator: step logic
// Next counter state and result fields for one request, from the current
// state registers and the configuration.
// ----------------------------------------------------------------------------
module ptg_step #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic [VALUE_WIDTH-1:0] total,
    input  logic                   three,
    input  logic                   permute_on,
    input  logic                   restart,
    input  logic [VALUE_WIDTH-1:0] lead,
    input  logic [VALUE_WIDTH-1:0] middle,
    input  logic [VALUE_WIDTH-1:0] tail,
    input  logic [VALUE_WIDTH-1:0] tuple_in   [3],
    input  ptg_pkg::perm_t         perm_in,
    output logic [VALUE_WIDTH-1:0] lead_next,
    output logic [VALUE_WIDTH-1:0] middle_next,
    output logic [VALUE_WIDTH-1:0] tail_next,
    output logic [VALUE_WIDTH-1:0] tuple_next [3],
    output ptg_pkg::perm_t         perm_next,
    output logic [VALUE_WIDTH-1:0] res_first,
    output logic [VALUE_WIDTH-1:0] res_second,
    output logic [VALUE_WIDTH-1:0] res_third,
    output logic                   res_valid,
    output logic                   more_now
);

    function automatic logic [VALUE_WIDTH-1:0] sub_sat(input logic [VALUE_WIDTH-1:0] a,
                                                      input logic [VALUE_WIDTH-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    logic [VALUE_WIDTH-1:0] swap_tuple [3];
    ptg_pkg::perm_t         swap_perm;

    logic [VALUE_WIDTH:0]   total_inc;
    logic [VALUE_WIDTH:0]   size_wide;
    logic [VALUE_WIDTH-1:0] reload_m;
    logic [VALUE_WIDTH-1:0] lead_inc;
    logic [VALUE_WIDTH-1:0] tail_dec;
    logic [VALUE_WIDTH-1:0] mid_try;
    logic [VALUE_WIDTH-1:0] rest_inc;
    logic [VALUE_WIDTH-1:0] tail_wrap;

    ptg_swap #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_swap (
        .tuple_in  (tuple_in),
        .three     (three),
        .perm_in   (perm_in),
        .tuple_out (swap_tuple),
        .perm_out  (swap_perm)
    );

    always_comb begin
        total_inc = {1'b0, total} + {{VALUE_WIDTH{1'b0}}, 1'b1};
        size_wide = three ? (VALUE_WIDTH+1)'(3) : (VALUE_WIDTH+1)'(2);
        reload_m  = (total_inc > size_wide) ? VALUE_WIDTH'(total_inc - size_wide) : '0;

        lead_inc  = lead + VALUE_WIDTH'(1);
        tail_dec  = sub_sat(tail, VALUE_WIDTH'(1));
        mid_try   = sub_sat(sub_sat(total, lead), tail_dec);
        rest_inc  = sub_sat(total, lead_inc);
        tail_wrap = sub_sat(rest_inc, lead_inc);

        more_now = (three ? (lead <= tail) : (lead <= middle))
                   || (permute_on && (perm_in.pending != ptg_pkg::PERM_NONE));

        lead_next   = lead;
        middle_next = middle;
        tail_next   = tail;
        tuple_next  = tuple_in;
        perm_next   = perm_in;
        res_valid   = 1'b0;

        if (restart) begin
            lead_next         = VALUE_WIDTH'(1);
            middle_next       = three ? VALUE_WIDTH'(1) : reload_m;
            tail_next         = three ? reload_m : '0;
            tuple_next[0]     = '0;
            tuple_next[1]     = '0;
            tuple_next[2]     = '0;
            perm_next.swap_pos = '0;
            perm_next.pending  = ptg_pkg::PERM_NONE;
        end else if (more_now) begin
            res_valid = 1'b1;
            if (permute_on && (perm_in.pending != ptg_pkg::PERM_NONE)) begin
                tuple_next = swap_tuple;
                perm_next  = swap_perm;
            end else if (!three) begin
                tuple_next[0]      = lead;
                tuple_next[1]      = middle;
                tuple_next[2]      = '0;
                lead_next          = lead_inc;
                middle_next        = rest_inc;
                perm_next.swap_pos = '0;
                perm_next.pending  = (lead == middle) ? ptg_pkg::PERM_NONE
                                                      : ptg_pkg::PERM_SINGLE;
            end else begin
                tuple_next[0]      = lead;
                tuple_next[1]      = middle;
                tuple_next[2]      = tail;
                perm_next.swap_pos = '0;
                if (mid_try > tail_dec) begin
                    // Middle part overtook the tail: move on to the next lead.
                    lead_next   = lead_inc;
                    middle_next = lead_inc;
                    tail_next   = tail_wrap;
                end else begin
                    middle_next = mid_try;
                    tail_next   = tail_dec;
                end
                if ((lead == middle) && (middle == tail)) begin
                    perm_next.pending = ptg_pkg::PERM_NONE;
                end else if ((lead == middle) || (lead == tail) || (middle == tail)) begin
                    perm_next.pending = ptg_pkg::PERM_ONE_PAIR;
                end else begin
                    perm_next.pending = ptg_pkg::PERM_ALL_DISTINCT;
                end
            end
        end

        res_first  = res_valid ? tuple_next[0] : '0;
        res_second = res_valid ? tuple_next[1] : '0;
        res_third  = (res_valid && three) ? tuple_next[2] : '0;
    end

endmodule
